@@ hdl/lcdns_pkg.sv @@
// Shared types, codes and init tables for the character LCD nibble sequencer.
package lcdns_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int INIT_STEPS  = 14;
    localparam int STEP_W      = $clog2(INIT_STEPS);

    localparam logic [7:0]  CURSOR_BASE   = 8'h80;
    localparam logic [7:0]  LINE2_OFFSET  = 8'h40;
    localparam logic [7:0]  CLEAR_CMD     = 8'h01;

    localparam logic [15:0] CHAR_DELAY_RST    = 16'd40;
    localparam logic [15:0] COMMAND_DELAY_RST = 16'd40;
    localparam logic [15:0] CLEAR_DELAY_RST   = 16'd1640;

    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_RAW    = 3'd1,
        ACT_CHAR   = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_CURSOR = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REG_CHAR_DELAY    = 2'd0,
        REG_COMMAND_DELAY = 2'd1,
        REG_CLEAR_DELAY   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] char_delay;
        logic [15:0] command_delay;
        logic [15:0] clear_delay;
    } cfg_t;

    // One queued request: either the whole init sequence or one byte
    typedef struct packed {
        logic        is_init;
        logic        rs;
        logic [7:0]  data_val;
        logic [15:0] delay;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Nibble sent at each step of the power-up sequence
    function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [3:0] nib;
        unique case (step)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3:             nib = 4'h2;
            4'd4:             nib = 4'h2;
            4'd5:             nib = 4'hB;
            4'd6:             nib = 4'h0;
            4'd7:             nib = 4'h8;
            4'd8:             nib = 4'h0;
            4'd9:             nib = 4'h1;
            4'd10:            nib = 4'h0;
            4'd11:            nib = 4'h6;
            4'd12:            nib = 4'h0;
            4'd13:            nib = 4'hC;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Idle wait ahead of the first three wake-up nibbles
    function automatic logic [13:0] init_wait_before(input logic [STEP_W-1:0] step);
        logic [13:0] w;
        unique case (step)
            4'd0:    w = 14'd15000;
            4'd1:    w = 14'd4100;
            4'd2:    w = 14'd100;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

    // Steps that carry the clear display byte
    function automatic logic init_is_clear(input logic [STEP_W-1:0] step);
        return (step == 4'd8) || (step == 4'd9);
    endfunction

endpackage

@@ hdl/lcdns_front.sv @@
// Front end: configuration registers and request classification into queue entries.
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  queue_status_t q_status,
    output logic        push,
    output entry_t      push_entry,
    output cfg_t        cfg
);

    logic [15:0] char_delay_reg;
    logic [15:0] command_delay_reg;
    logic [15:0] clear_delay_reg;

    logic [7:0]  data_byte;
    logic [15:0] delay_us;
    logic [5:0]  column;
    logic        second_line;
    logic        register_select;
    action_t     action;
    logic        valid_action;
    logic [7:0]  cursor_addr;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_delay_reg    <= CHAR_DELAY_RST;
            command_delay_reg <= COMMAND_DELAY_RST;
            clear_delay_reg   <= CLEAR_DELAY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CHAR_DELAY:    char_delay_reg    <= cfg_wdata;
                REG_COMMAND_DELAY: command_delay_reg <= cfg_wdata;
                REG_CLEAR_DELAY:   clear_delay_reg   <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign cfg = '{char_delay: char_delay_reg,
                   command_delay: command_delay_reg,
                   clear_delay: clear_delay_reg};

    // Unpack the request
    assign action          = action_t'(s_tuser[2:0]);
    assign register_select = s_tuser[3];
    assign data_byte       = s_tdata[7:0];
    assign delay_us        = s_tdata[23:8];
    assign column          = s_tdata[29:24];
    assign second_line     = s_tdata[30];

    assign cursor_addr = CURSOR_BASE + {2'b00, column} + (second_line ? LINE2_OFFSET : 8'h00);

    // Classify the request into an init run or a single byte
    always_comb
    begin
        valid_action        = 1'b1;
        push_entry.is_init  = 1'b0;
        push_entry.rs       = 1'b0;
        push_entry.data_val = data_byte;
        push_entry.delay    = command_delay_reg;
        unique case (action)
            ACT_INIT:
            begin
                push_entry.is_init = 1'b1;
            end
            ACT_RAW:
            begin
                push_entry.rs    = register_select;
                push_entry.delay = delay_us;
            end
            ACT_CHAR:
            begin
                push_entry.rs    = 1'b1;
                push_entry.delay = char_delay_reg;
            end
            ACT_CLEAR:
            begin
                push_entry.data_val = CLEAR_CMD;
                push_entry.delay    = clear_delay_reg;
            end
            ACT_CURSOR:
            begin
                push_entry.data_val = cursor_addr;
            end
            default:
            begin
                valid_action = 1'b0;
            end
        endcase
    end

    // Take requests while the queue has room; drop unused action codes
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready && valid_action;

endmodule

@@ hdl/lcdns_queue.sv @@
// Short request queue between the front end and the nibble sequencer.
module lcdns_queue
    import lcdns_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t q_status
);

    entry_t              slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign q_status.full  = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head = slots[rd_ptr_reg];

endmodule

@@ hdl/lcdns_back.sv @@
// Back end: steps through the head request and drives one nibble transaction per cycle while the output is not stalled.
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  entry_t        head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic              rs_reg;
    logic [3:0]        nibble_reg;
    logic [13:0]       wait_before_reg;
    logic [15:0]       wait_after_reg;
    logic              last_reg;

    logic              advance;
    logic              rs_c;
    logic [3:0]        nibble_c;
    logic [13:0]       wait_before_c;
    logic [15:0]       wait_after_c;
    logic              last_c;

    assign advance = !q_status.empty && (!m_tvalid_reg || m_tready);

    // Build the nibble for the current step
    always_comb
    begin
        if (head.is_init)
        begin
            rs_c          = 1'b0;
            nibble_c      = init_nibble(step_reg);
            wait_before_c = init_wait_before(step_reg);
            wait_after_c  = init_is_clear(step_reg) ? cfg.clear_delay : cfg.command_delay;
            last_c        = (step_reg == STEP_W'(INIT_STEPS - 1));
        end
        else
        begin
            rs_c          = head.rs;
            nibble_c      = step_reg[0] ? head.data_val[3:0] : head.data_val[7:4];
            wait_before_c = 14'd0;
            wait_after_c  = head.delay;
            last_c        = step_reg[0];
        end
    end

    // Step and output valid next state
    always_comb
    begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        if (advance)
        begin
            step_next     = last_c ? '0 : step_reg + 1'b1;
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign pop = advance && last_c;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rs_reg          <= rs_c;
            nibble_reg      <= nibble_c;
            wait_before_reg <= wait_before_c;
            wait_after_reg  <= wait_after_c;
            last_reg        <= last_c;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, wait_after_reg, wait_before_reg, nibble_reg};
    assign m_tuser  = rs_reg;
    assign m_tlast  = last_reg;

endmodule

@@ hdl/char_lcd_nibble_sequencer.sv @@
// Top level of the character LCD nibble sequencer.
//
// Requests enter on the s_ stream: tuser carries the action code and the
// raw-write register select, tdata the byte, raw delay, column and line flag.
// Each request becomes nibble transactions on the m_ stream, upper nibble
// first, with tlast on the final one; tuser carries the RS level and tdata the
// nibble and the waits before and after the enable pulse.
// A request passes the queue, then the output register, to its first nibble.
// The output register gives one nibble per cycle while m_tready holds, so byte
// requests (raw, character, clear, cursor) are 2 nibbles and init is 14.
// Unused action codes are accepted and produce nothing.
// A four-entry request queue decouples input from output: requests keep being
// taken while the receiver stalls, until the queue fills and s_tready drops.
// A stalled nibble holds on m_ until taken. Reset clears the queue and output
// valid and loads the delay registers with 40, 40 and 1640 us. The user must
// write configuration only while the block is idle; the block does not check.
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte[7:0], delay_us[23:8], column[29:24],
                                   // second_line[30], zero[31]
    input  logic [3:0]  s_tuser,   // action[2:0], register_select[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // nibble[3:0], wait_before_us[17:4],
                                   // wait_after_us[33:18], zero[39:34]
    output logic        m_tuser,   // rs_level[0]
    output logic        m_tlast
);

    cfg_t          cfg;
    entry_t        push_entry;
    entry_t        head;
    queue_status_t q_status;
    logic          push;
    logic          pop;

    lcdns_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry),
        .cfg        (cfg)
    );

    lcdns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    lcdns_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hdl/lcdns_checker.sv @@
// Port-level checks for the character LCD nibble sequencer, bound to the top level.
module lcdns_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Stalled transaction holds valid and payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output transaction changed");

    // A pre-transfer wait only appears on init nibbles: RS low, never the last one
    a_wait_before_init: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[17:4] != 14'd0) |-> !m_tuser && !m_tlast)
        else $error("wait before transfer on a non-init nibble");

    // The rest of a request follows without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a request");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ verif/tb.sv @@
// Self-checking testbench for the character LCD nibble sequencer.
module tb;
    import lcdns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Action codes the block accepts but turns into no transfer
    localparam logic [2:0] ACT_UNUSED5 = 3'd5;
    localparam logic [2:0] ACT_UNUSED6 = 3'd6;
    localparam logic [2:0] ACT_UNUSED7 = 3'd7;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 150;
    // Slowest legal gap is the long receiver hold; allow many times that
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct {
        logic [2:0]  action;
        logic [7:0]  data_byte;
        logic        register_select;
        logic [15:0] delay_us;
        logic [5:0]  column;
        logic        second_line;
    } lcd_request_t;

    typedef struct {
        logic        rs_level;
        logic [3:0]  nibble;
        logic [13:0] wait_before_us;
        logic [15:0] wait_after_us;
        logic        last;
    } nibble_xfer_t;

    // Directed row: either checked by the predictor or with a typed-in byte
    typedef struct {
        lcd_request_t req;
        logic         typed;
        logic         emits;
        logic         t_rs;
        logic [7:0]   t_byte;
        logic [15:0]  t_after;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_CHAR_DELAY;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // data_byte[7:0], delay_us[23:8], column[29:24],
                                 // second_line[30], zero[31]
    logic [3:0]  s_tuser = '0;   // action[2:0], register_select[3]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // nibble[3:0], wait_before_us[17:4],
                                 // wait_after_us[33:18], zero[39:34]
    logic        m_tuser;        // rs_level[0]
    logic        m_tlast;

    // Delay registers as the block should hold them
    logic [15:0] char_delay    = CHAR_DELAY_RST;
    logic [15:0] command_delay = COMMAND_DELAY_RST;
    logic [15:0] clear_delay   = CLEAR_DELAY_RST;

    nibble_xfer_t expected_xfers[$];
    int errors = 0;
    int xfers_checked = 0;
    int settings_used = 1;
    int action_count[8];
    int idle_cycles = 0;
    logic tx_no_idle = 1'b0;
    logic stall_armed = 1'b0;
    logic stall_done = 1'b0;

    directed_row_t directed_rows[20] = '{
        '{'{ACT_INIT,   8'h00, 1'b0, 16'h0000, 6'd0,  1'b0}, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0},
        '{'{ACT_RAW,    8'h00, 1'b0, 16'h0000, 6'd0,  1'b0}, 1'b1, 1'b1, 1'b0, 8'h00, 16'h0000},
        '{'{ACT_RAW,    8'hFF, 1'b1, 16'hFFFF, 6'd0,  1'b0}, 1'b1, 1'b1, 1'b1, 8'hFF, 16'hFFFF},
        '{'{ACT_RAW,    8'h5A, 1'b0, 16'hA5A5, 6'd63, 1'b1}, 1'b1, 1'b1, 1'b0, 8'h5A, 16'hA5A5},
        '{'{ACT_CHAR,   8'h41, 1'b0, 16'h0000, 6'd0,  1'b0},
          1'b1, 1'b1, 1'b1, 8'h41, CHAR_DELAY_RST},
        '{'{ACT_CHAR,   8'hFF, 1'b1, 16'hFFFF, 6'd63, 1'b1},
          1'b1, 1'b1, 1'b1, 8'hFF, CHAR_DELAY_RST},
        '{'{ACT_CHAR,   8'h00, 1'b0, 16'h0000, 6'd0,  1'b0},
          1'b1, 1'b1, 1'b1, 8'h00, CHAR_DELAY_RST},
        '{'{ACT_CLEAR,  8'h00, 1'b0, 16'h0000, 6'd0,  1'b0},
          1'b1, 1'b1, 1'b0, CLEAR_CMD, CLEAR_DELAY_RST},
        '{'{ACT_CLEAR,  8'hFF, 1'b1, 16'hFFFF, 6'd63, 1'b1},
          1'b1, 1'b1, 1'b0, CLEAR_CMD, CLEAR_DELAY_RST},
        '{'{ACT_CURSOR, 8'h00, 1'b0, 16'h0000, 6'd0,  1'b0},
          1'b1, 1'b1, 1'b0, 8'h80, COMMAND_DELAY_RST},
        '{'{ACT_CURSOR, 8'h00, 1'b0, 16'h0000, 6'd63, 1'b1},
          1'b1, 1'b1, 1'b0, 8'hFF, COMMAND_DELAY_RST},
        '{'{ACT_CURSOR, 8'h00, 1'b0, 16'h0000, 6'd63, 1'b0},
          1'b1, 1'b1, 1'b0, 8'hBF, COMMAND_DELAY_RST},
        '{'{ACT_CURSOR, 8'h00, 1'b0, 16'h0000, 6'd0,  1'b1},
          1'b1, 1'b1, 1'b0, 8'hC0, COMMAND_DELAY_RST},
        '{'{ACT_CURSOR, 8'hFF, 1'b1, 16'hFFFF, 6'd21, 1'b0}, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0},
        '{'{ACT_UNUSED5, 8'h00, 1'b0, 16'h0000, 6'd0, 1'b0}, 1'b1, 1'b0, 1'b0, 8'h00, 16'h0},
        '{'{ACT_UNUSED6, 8'hFF, 1'b1, 16'hFFFF, 6'd63, 1'b1}, 1'b1, 1'b0, 1'b0, 8'h00, 16'h0},
        '{'{ACT_UNUSED7, 8'h3C, 1'b0, 16'h1234, 6'd7, 1'b0}, 1'b1, 1'b0, 1'b0, 8'h00, 16'h0},
        '{'{ACT_INIT,   8'hFF, 1'b1, 16'hFFFF, 6'd63, 1'b1}, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0},
        '{'{ACT_RAW,    8'hA5, 1'b1, 16'h1234, 6'd42, 1'b1}, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0},
        '{'{ACT_CHAR,   8'h7E, 1'b0, 16'h8001, 6'd1,  1'b0}, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0}
    };

    char_lcd_nibble_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Queue one nibble transfer that the block should emit
    function automatic void queue_nibble(input logic rs, input logic [3:0] nib,
                                         input logic [13:0] wait_pre,
                                         input logic [15:0] after);
        nibble_xfer_t x;
        x.rs_level       = rs;
        x.nibble         = nib;
        x.wait_before_us = wait_pre;
        x.wait_after_us  = after;
        x.last           = 1'b0;
        expected_xfers.push_back(x);
    endfunction

    // Upper nibble goes out first
    function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                       input logic [15:0] after);
        queue_nibble(rs, b[7:4], 14'd0, after);
        queue_nibble(rs, b[3:0], 14'd0, after);
    endfunction

    function automatic void mark_last(input int first_new);
        if (expected_xfers.size() > first_new)
            expected_xfers[expected_xfers.size() - 1].last = 1'b1;
    endfunction

    // Work out the transfers one request should produce
    function automatic void predict_transfers(input lcd_request_t r);
        int         first_new = expected_xfers.size();
        logic [7:0] cursor_addr;
        case (r.action)
            ACT_INIT:
            begin
                queue_nibble(1'b0, 4'h3, 14'd15000, command_delay);
                queue_nibble(1'b0, 4'h3, 14'd4100, command_delay);
                queue_nibble(1'b0, 4'h3, 14'd100, command_delay);
                queue_nibble(1'b0, 4'h2, 14'd0, command_delay);
                queue_byte(1'b0, 8'h2B, command_delay);
                queue_byte(1'b0, 8'h08, command_delay);
                queue_byte(1'b0, CLEAR_CMD, clear_delay);
                queue_byte(1'b0, 8'h06, command_delay);
                queue_byte(1'b0, 8'h0C, command_delay);
            end
            ACT_RAW:   queue_byte(r.register_select, r.data_byte, r.delay_us);
            ACT_CHAR:  queue_byte(1'b1, r.data_byte, char_delay);
            ACT_CLEAR: queue_byte(1'b0, CLEAR_CMD, clear_delay);
            ACT_CURSOR:
            begin
                cursor_addr = CURSOR_BASE + {2'b00, r.column}
                              + (r.second_line ? LINE2_OFFSET : 8'h00);
                queue_byte(1'b0, cursor_addr, command_delay);
            end
            default: ;
        endcase
        mark_last(first_new);
    endfunction

    // Compare one received transfer with the oldest expectation
    function automatic void check_transfer(input logic [39:0] data, input logic user,
                                           input logic tl);
        nibble_xfer_t want;
        if (expected_xfers.size() == 0)
        begin
            $error("unexpected nibble transfer: tdata %h tuser %b tlast %b", data, user, tl);
            errors++;
            return;
        end
        want = expected_xfers.pop_front();
        xfers_checked++;
        if (user !== want.rs_level)
        begin
            $error("rs_level: expected %0d, got %0d", want.rs_level, user);
            errors++;
        end
        if (data[3:0] !== want.nibble)
        begin
            $error("nibble: expected %h, got %h", want.nibble, data[3:0]);
            errors++;
        end
        if (data[17:4] !== want.wait_before_us)
        begin
            $error("wait_before_us: expected %0d, got %0d", want.wait_before_us, data[17:4]);
            errors++;
        end
        if (data[33:18] !== want.wait_after_us)
        begin
            $error("wait_after_us: expected %0d, got %0d", want.wait_after_us, data[33:18]);
            errors++;
        end
        if (tl !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, tl);
            errors++;
        end
    endfunction

    function automatic int next_gap();
        if ($urandom_range(0, 24) == 0)
            tx_no_idle = ~tx_no_idle;
        return tx_no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    // Mostly real commands with noise in the fields the action ignores
    function automatic lcd_request_t random_request();
        lcd_request_t r;
        int           pick = $urandom_range(0, 99);
        int           dly_pick = $urandom_range(0, 7);
        if (pick < 5)
            r.action = ACT_INIT;
        else if (pick < 30)
            r.action = ACT_RAW;
        else if (pick < 55)
            r.action = ACT_CHAR;
        else if (pick < 65)
            r.action = ACT_CLEAR;
        else if (pick < 92)
            r.action = ACT_CURSOR;
        else
            r.action = 3'($urandom_range(ACT_UNUSED5, ACT_UNUSED7));
        r.data_byte       = 8'($urandom);
        r.register_select = 1'($urandom);
        r.column          = 6'($urandom);
        r.second_line     = 1'($urandom);
        if (dly_pick == 0)
            r.delay_us = 16'h0000;
        else if (dly_pick == 1)
            r.delay_us = 16'hFFFF;
        else
            r.delay_us = 16'($urandom);
        return r;
    endfunction

    // Offer one request and hold it until the transaction completes
    task automatic send_request(input lcd_request_t r, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.second_line, r.column, r.delay_us, r.data_byte};
        s_tuser  <= {r.register_select, r.action};
        do @(posedge clk); while (!s_tready);
        action_count[r.action]++;
    endtask

    // Drop valid and wait until every expected transfer has arrived
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (expected_xfers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            REG_CHAR_DELAY:    char_delay    = value;
            REG_COMMAND_DELAY: command_delay = value;
            REG_CLEAR_DELAY:   clear_delay   = value;
            default: ;
        endcase
    endtask

    // Stimulus: reset, directed table, then random phases between config changes
    initial
    begin
        lcd_request_t r;
        logic [15:0]  new_char;
        logic [15:0]  new_cmd;
        logic [15:0]  new_clear;
        foreach (action_count[i])
            action_count[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req, next_gap());
            if (directed_rows[i].typed)
            begin
                if (directed_rows[i].emits)
                begin
                    queue_byte(directed_rows[i].t_rs, directed_rows[i].t_byte,
                               directed_rows[i].t_after);
                    expected_xfers[expected_xfers.size() - 1].last = 1'b1;
                end
            end
            else
                predict_transfers(directed_rows[i].req);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_requests();
            case (ph)
                0:
                begin
                    new_char  = 16'h0000;
                    new_cmd   = 16'h0000;
                    new_clear = 16'h0000;
                end
                1:
                begin
                    new_char  = 16'hFFFF;
                    new_cmd   = 16'hFFFF;
                    new_clear = 16'hFFFF;
                end
                3:
                begin
                    new_char  = 16'hFFFF;
                    new_cmd   = 16'h0000;
                    new_clear = 16'hFFFF;
                end
                4:
                begin
                    new_char  = 16'h0000;
                    new_cmd   = 16'hFFFF;
                    new_clear = 16'h0001;
                end
                default:
                begin
                    new_char  = 16'($urandom);
                    new_cmd   = 16'($urandom);
                    new_clear = 16'($urandom);
                end
            endcase
            write_cfg(REG_CHAR_DELAY, new_char);
            write_cfg(REG_COMMAND_DELAY, new_cmd);
            write_cfg(REG_CLEAR_DELAY, new_clear);
            cfg_wr_en <= 1'b0;
            settings_used++;
            // Hold the receiver off once so the request queue fills
            if (ph == 1)
                stall_armed = 1'b1;
            repeat (ITEMS_PER_PHASE)
            begin
                r = random_request();
                send_request(r, next_gap());
                predict_transfers(r);
            end
        end
        drain_requests();

        $display("Covered %0d init, %0d raw, %0d char, %0d clear, %0d cursor requests",
                 action_count[ACT_INIT], action_count[ACT_RAW], action_count[ACT_CHAR],
                 action_count[ACT_CLEAR], action_count[ACT_CURSOR]);
        $display("plus %0d unused codes; %0d nibble transfers checked over %0d delay settings",
                 action_count[ACT_UNUSED5] + action_count[ACT_UNUSED6]
                 + action_count[ACT_UNUSED7], xfers_checked, settings_used);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: check each transaction, then draw the stall before the next
    initial
    begin : receiver
        int   rx_wait;
        logic rx_no_idle;
        rx_wait    = 0;
        rx_no_idle = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                check_transfer(m_tdata, m_tuser, m_tlast);
                if ($urandom_range(0, 39) == 0)
                    rx_no_idle = ~rx_no_idle;
                rx_wait = rx_no_idle ? 0 : $urandom_range(0, 3);
                if (stall_armed && !stall_done)
                begin
                    rx_wait    = HOLD_CYCLES;
                    stall_done = 1'b1;
                end
            end
            if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

@@ sim.f @@
hdl/lcdns_pkg.sv
hdl/lcdns_front.sv
hdl/lcdns_queue.sv
hdl/lcdns_back.sv
hdl/char_lcd_nibble_sequencer.sv
hdl/lcdns_checker.sv
verif/tb.sv
